// ===== rtl/l3sf_pkg.sv =====
`default_nettype none

package l3sf_pkg;

   // Command codes on the request channel
   localparam logic CMD_START = 1'b0;
   localparam logic CMD_BIT   = 1'b1;

   // Side-info block type that selects short windows
   localparam logic [1:0] BLOCK_TYPE_SHORT = 2'd2;

   localparam logic [4:0] LONG_BANDS       = 5'd21;
   localparam logic [4:0] MIXED_LONG_BANDS = 5'd8;
   localparam logic [4:0] MIXED_SHORT_BASE = 5'd5;
   localparam logic [4:0] SHORT_PAD_BAND   = 5'd12;
   localparam logic [4:0] LONG_SLEN2_START = 5'd11;
   localparam logic [4:0] SHORT_SLEN2_START = 5'd6;
   localparam logic [1:0] LAST_WINDOW      = 2'd2;

   // First band past each scfsi group: 6, 11, 16, 21
   localparam logic [4:0] GROUP1_START = 5'd6;
   localparam logic [4:0] GROUP2_START = 5'd11;
   localparam logic [4:0] GROUP3_START = 5'd16;

   localparam int STORE_DEPTH = 42;
   localparam int STORE_AW    = 6;

   // slen1 / slen2 by compress index
   localparam logic [2:0] SLEN_FIRST [16] = '{
      3'd0, 3'd0, 3'd0, 3'd0, 3'd3, 3'd1, 3'd1, 3'd1,
      3'd2, 3'd2, 3'd2, 3'd3, 3'd3, 3'd3, 3'd4, 3'd4
   };
   localparam logic [2:0] SLEN_SECOND [16] = '{
      3'd0, 3'd1, 3'd2, 3'd3, 3'd0, 3'd1, 3'd2, 3'd3,
      3'd1, 3'd2, 3'd3, 3'd1, 3'd2, 3'd3, 3'd2, 3'd3
   };

   typedef enum logic [1:0] {
      MODE_IDLE,
      MODE_LONG,
      MODE_SHORT,
      MODE_MIXED
   } mode_type;

   typedef enum logic [1:0] {
      ST_IDLE,   // no granule open
      ST_BITS,   // shifting in bits of the current factor
      ST_NEXT,   // look at the next slot
      ST_COPY    // store read in flight for a copied factor
   } state_type;

   // Description of the slot at the current band/window position
   typedef struct packed {
      logic [2:0] width;
      logic       copy;
      logic       pad;
      logic       is_short;
      logic [4:0] band;
      logic [1:0] window;
      logic       last;
   } slot_type;

endpackage : l3sf_pkg

`default_nettype wire

// ===== rtl/layer3_scalefactor_unpacker.sv =====
`default_nettype none

// Channel   Direction  Handshake             Payload
// req_      in         req_valid/req_stall   command, data bit, side info of a granule
// rsp_      out        rsp_valid/rsp_stall   factor value, band, window, flags, bit count
//
// Main-data bits enter one per cycle while a factor is being shifted in, unless
// the response side stalls; the 4-bit shift register and its bit counter set that pace.
// Each zero-width or padded factor, and each slot that opens a new bit field,
// passes through ST_NEXT; a copied factor also waits in ST_COPY (registered store read).
// The request side is stalled in ST_NEXT and ST_COPY, and whenever a finished
// transaction sits in the response register and is itself stalled.
// Synchronous reset clears control only; the granule-0 store is undefined
// until written.

module layer3_scalefactor_unpacker (
   input  wire logic       clock,
   input  wire logic       reset,

   input  wire logic       req_valid,
   output var  logic       req_stall,
   input  wire logic       req_command,
   input  wire logic       req_data_bit,
   input  wire logic       req_granule,
   input  wire logic       req_channel,
   input  wire logic [1:0] req_block_type,
   input  wire logic       req_window_switch,
   input  wire logic       req_mixed_flag,
   input  wire logic [3:0] req_compress_index,
   input  wire logic [3:0] req_reuse_groups,

   output var  logic       rsp_valid,
   input  wire logic       rsp_stall,
   output var  logic [3:0] rsp_factor_value,
   output var  logic [4:0] rsp_band,
   output var  logic [1:0] rsp_window,
   output var  logic       rsp_is_short,
   output var  logic       rsp_last,
   output var  logic [6:0] rsp_part2_bits
);
   import l3sf_pkg::*;

   // Control state
   state_type  state_ff, state_in;
   mode_type   mode_ff, mode_in;
   logic [4:0] band_ff, band_in;
   logic [1:0] window_ff, window_in;
   logic [3:0] shift_ff, shift_in;
   logic [2:0] left_ff, left_in;
   logic [6:0] consumed_ff, consumed_in;

   // Latched side info (only what the slot walk needs)
   logic       granule_ff, granule_in;
   logic       channel_ff, channel_in;
   logic [3:0] compress_ff, compress_in;
   logic [3:0] reuse_ff, reuse_in;

   // Response register
   logic       rsp_valid_ff, rsp_valid_in;
   logic [3:0] value_ff, value_in;
   logic [4:0] band_out_ff, band_out_in;
   logic [1:0] window_out_ff, window_out_in;
   logic       short_out_ff, short_out_in;
   logic       last_out_ff, last_out_in;
   logic [6:0] part2_ff, part2_in;

   // Granule-0 long-band store
   logic [3:0] store_mem [STORE_DEPTH];
   logic [3:0] store_rd_ff;
   logic       store_wr_en;
   logic       store_rd_en;
   logic [STORE_AW-1:0] store_addr;

   slot_type   slot;
   logic       out_free;
   logic       req_take;
   logic       emit;
   logic [3:0] emit_value;
   logic [4:0] band_adv;
   logic [1:0] window_adv;
   logic [2:0] window_inc;

   l3sf_slot u_slot (
      .mode         (mode_ff),
      .band_index   (band_ff),
      .window_index (window_ff),
      .granule      (granule_ff),
      .compress     (compress_ff),
      .reuse        (reuse_ff),
      .slot         (slot)
   );

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff == ST_NEXT) || (state_ff == ST_COPY) || !out_free;
   assign req_take  = req_valid && !req_stall;

   // Position after the current slot
   always_comb begin
      window_inc = {1'b0, window_ff} + 3'd1;
      if (slot.is_short) begin
         if (window_inc >= 3'd3) begin
            window_adv = '0;
            band_adv   = band_ff + 5'd1;
         end else begin
            window_adv = window_inc[1:0];
            band_adv   = band_ff;
         end
      end else begin
         window_adv = '0;
         band_adv   = band_ff + 5'd1;
      end
   end

   // Store address: channel * 21 + band, same for write and read
   assign store_addr = channel_ff ? STORE_AW'({1'b0, LONG_BANDS} + {1'b0, slot.band})
                                  : STORE_AW'(slot.band);

   always_comb begin
      state_in    = state_ff;
      mode_in     = mode_ff;
      band_in     = band_ff;
      window_in   = window_ff;
      shift_in    = shift_ff;
      left_in     = left_ff;
      consumed_in = consumed_ff;
      granule_in  = granule_ff;
      channel_in  = channel_ff;
      compress_in = compress_ff;
      reuse_in    = reuse_ff;
      emit        = 1'b0;
      emit_value  = '0;
      store_rd_en = 1'b0;

      unique case (state_ff) inside
         ST_IDLE, ST_BITS: begin
            if (req_take) begin
               if (req_command == CMD_START) begin
                  granule_in  = req_granule;
                  channel_in  = req_channel;
                  compress_in = req_compress_index;
                  reuse_in    = req_reuse_groups;
                  if (req_block_type == BLOCK_TYPE_SHORT && req_window_switch) begin
                     mode_in = req_mixed_flag ? MODE_MIXED : MODE_SHORT;
                  end else begin
                     mode_in = MODE_LONG;
                  end
                  band_in     = '0;
                  window_in   = '0;
                  shift_in    = '0;
                  left_in     = '0;
                  consumed_in = '0;
                  state_in    = ST_NEXT;
               end else if (state_ff == ST_BITS) begin
                  // Bits arriving with no granule open are dropped
                  shift_in    = {shift_ff[2:0], req_data_bit};
                  consumed_in = consumed_ff + 7'd1;
                  left_in     = left_ff - 3'd1;
                  if (left_ff == 3'd1) begin
                     emit       = 1'b1;
                     emit_value = shift_in;
                     shift_in   = '0;
                     band_in    = band_adv;
                     window_in  = window_adv;
                     state_in   = ST_NEXT;
                  end
               end
            end
         end
         ST_NEXT: begin
            if (out_free) begin
               if (slot.pad || (!slot.copy && slot.width == 3'd0)) begin
                  emit       = 1'b1;
                  emit_value = '0;
                  if (slot.last) begin
                     mode_in  = MODE_IDLE;
                     state_in = ST_IDLE;
                  end else begin
                     band_in   = band_adv;
                     window_in = window_adv;
                  end
               end else if (slot.copy) begin
                  store_rd_en = 1'b1;
                  state_in    = ST_COPY;
               end else begin
                  left_in  = slot.width;
                  shift_in = '0;
                  state_in = ST_BITS;
               end
            end
         end
         ST_COPY: begin
            if (out_free) begin
               emit       = 1'b1;
               emit_value = store_rd_ff;
               band_in    = band_adv;
               window_in  = window_adv;
               state_in   = ST_NEXT;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Granule-0 long factors are kept for scfsi copies in granule 1
   assign store_wr_en = emit && !granule_ff && !slot.is_short && (slot.band < LONG_BANDS);

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      value_in      = value_ff;
      band_out_in   = band_out_ff;
      window_out_in = window_out_ff;
      short_out_in  = short_out_ff;
      last_out_in   = last_out_ff;
      part2_in      = part2_ff;
      if (emit) begin
         rsp_valid_in  = 1'b1;
         value_in      = emit_value;
         band_out_in   = slot.band;
         window_out_in = slot.window;
         short_out_in  = slot.is_short;
         last_out_in   = slot.last;
         part2_in      = consumed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= MODE_IDLE;
         band_ff      <= '0;
         window_ff    <= '0;
         shift_ff     <= '0;
         left_ff      <= '0;
         consumed_ff  <= '0;
         granule_ff   <= 1'b0;
         channel_ff   <= 1'b0;
         compress_ff  <= '0;
         reuse_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         band_ff      <= band_in;
         window_ff    <= window_in;
         shift_ff     <= shift_in;
         left_ff      <= left_in;
         consumed_ff  <= consumed_in;
         granule_ff   <= granule_in;
         channel_ff   <= channel_in;
         compress_ff  <= compress_in;
         reuse_ff     <= reuse_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff      <= value_in;
      band_out_ff   <= band_out_in;
      window_out_ff <= window_out_in;
      short_out_ff  <= short_out_in;
      last_out_ff   <= last_out_in;
      part2_ff      <= part2_in;
   end

   always_ff @(posedge clock) begin
      if (store_wr_en) begin
         store_mem[store_addr] <= emit_value;
      end
      if (store_rd_en) begin
         store_rd_ff <= store_mem[store_addr];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_factor_value = value_ff;
   assign rsp_band         = band_out_ff;
   assign rsp_window       = window_out_ff;
   assign rsp_is_short     = short_out_ff;
   assign rsp_last         = last_out_ff;
   assign rsp_part2_bits   = part2_ff;

endmodule : layer3_scalefactor_unpacker

`default_nettype wire

// ===== rtl/l3sf_slot.sv =====
`default_nettype none

module l3sf_slot (
   input  var l3sf_pkg::mode_type mode,
   input  wire logic [4:0]        band_index,
   input  wire logic [1:0]        window_index,
   input  wire logic              granule,
   input  wire logic [3:0]        compress,
   input  wire logic [3:0]        reuse,
   output var l3sf_pkg::slot_type slot
);
   import l3sf_pkg::*;

   logic [2:0] slen1;
   logic [2:0] slen2;
   logic       long_side;
   logic [4:0] sfb;
   logic [1:0] group_sel;

   assign slen1 = SLEN_FIRST[compress];
   assign slen2 = SLEN_SECOND[compress];
   assign long_side = (mode == MODE_LONG) ||
                      ((mode == MODE_MIXED) && (band_index < MIXED_LONG_BANDS));

   always_comb begin
      if (band_index < GROUP1_START) begin
         group_sel = 2'd0;
      end else if (band_index < GROUP2_START) begin
         group_sel = 2'd1;
      end else if (band_index < GROUP3_START) begin
         group_sel = 2'd2;
      end else begin
         group_sel = 2'd3;
      end
   end

   always_comb begin
      sfb = (mode == MODE_MIXED) ? band_index - MIXED_SHORT_BASE : band_index;
      if (sfb > SHORT_PAD_BAND) begin
         sfb = SHORT_PAD_BAND;
      end
   end

   always_comb begin
      slot = '0;
      if (long_side) begin
         slot.band = band_index;
         if (mode == MODE_MIXED) begin
            slot.width = slen1;
         end else if (band_index >= LONG_BANDS) begin
            slot.pad  = 1'b1;
            slot.last = 1'b1;
            slot.band = LONG_BANDS;
         end else begin
            slot.width = (band_index < LONG_SLEN2_START) ? slen1 : slen2;
            slot.copy  = granule && reuse[group_sel];
         end
      end else begin
         slot.is_short = 1'b1;
         slot.band     = sfb;
         slot.window   = window_index;
         if (sfb >= SHORT_PAD_BAND) begin
            slot.pad  = 1'b1;
            slot.last = (window_index >= LAST_WINDOW);
         end else begin
            slot.width = (sfb < SHORT_SLEN2_START) ? slen1 : slen2;
         end
      end
   end

endmodule : l3sf_slot

`default_nettype wire

// ===== test/l3sf_checker.sv =====
`timescale 1ns / 1ps

module l3sf_checker (
   input  wire logic                   clock,
   input  wire logic                   reset,

   input  wire logic                   req_valid,
   input  wire logic                   req_stall,
   input  wire logic                   req_command,
   input  wire logic                   req_data_bit,
   input  wire logic                   req_granule,
   input  wire logic                   req_channel,
   input  wire logic [1:0]             req_block_type,
   input  wire logic                   req_window_switch,
   input  wire logic                   req_mixed_flag,
   input  wire logic [3:0]             req_compress_index,
   input  wire logic [3:0]             req_reuse_groups,

   input  wire logic                   rsp_valid,
   input  wire logic                   rsp_stall,
   input  wire logic [3:0]             rsp_factor_value,
   input  wire logic [4:0]             rsp_band,
   input  wire logic [1:0]             rsp_window,
   input  wire logic                   rsp_is_short,
   input  wire logic                   rsp_last,
   input  wire logic [6:0]             rsp_part2_bits,

   output int                          mismatches,
   output int                          pending_factors,
   output logic [l3sf_pkg::STORE_DEPTH-1:0] store_filled
);
   import l3sf_pkg::*;

   typedef struct packed {
      logic [3:0] value;
      logic [4:0] band;
      logic [1:0] window;
      logic       is_short;
      logic       last;
      logic [6:0] part2;
   } factor_type;

   // Shadow of the unpacker
   mode_type   gran_mode;
   logic [4:0] band_pos;
   logic [1:0] win_pos;
   logic [3:0] acc;
   logic [2:0] bits_owed;
   logic [6:0] bits_used;
   logic       si_granule;
   logic       si_channel;
   logic [3:0] si_compress;
   logic [3:0] si_reuse;
   logic [3:0] g0_store [STORE_DEPTH];

   factor_type expected_factors [$];

   function automatic int store_index(input logic ch, input logic [4:0] band);
      return int'(ch) * int'(LONG_BANDS) + int'(band);
   endfunction

   // What the slot at the current band/window position looks like
   function automatic slot_type current_slot();
      slot_type   s;
      logic [4:0] sfb;
      logic [1:0] grp;
      s = '0;
      if (gran_mode == MODE_LONG || (gran_mode == MODE_MIXED && band_pos < MIXED_LONG_BANDS)) begin
         s.band = band_pos;
         if (gran_mode == MODE_MIXED) begin
            s.width = SLEN_FIRST[si_compress];
         end else if (band_pos >= LONG_BANDS) begin
            s.pad  = 1'b1;
            s.last = 1'b1;
            s.band = LONG_BANDS;
         end else begin
            s.width = (band_pos < LONG_SLEN2_START) ? SLEN_FIRST[si_compress]
                                                    : SLEN_SECOND[si_compress];
            grp = (band_pos >= GROUP3_START) ? 2'd3 :
                  (band_pos >= GROUP2_START) ? 2'd2 :
                  (band_pos >= GROUP1_START) ? 2'd1 : 2'd0;
            s.copy = si_granule && si_reuse[grp];
         end
      end else begin
         sfb = (gran_mode == MODE_MIXED) ? band_pos - MIXED_SHORT_BASE : band_pos;
         if (sfb > SHORT_PAD_BAND)
            sfb = SHORT_PAD_BAND;
         s.is_short = 1'b1;
         s.band     = sfb;
         s.window   = win_pos;
         if (sfb >= SHORT_PAD_BAND) begin
            s.pad  = 1'b1;
            s.last = (win_pos >= LAST_WINDOW);
         end else begin
            s.width = (sfb < SHORT_SLEN2_START) ? SLEN_FIRST[si_compress]
                                                : SLEN_SECOND[si_compress];
         end
      end
      return s;
   endfunction

   task automatic record_factor(input slot_type s, input logic [3:0] v);
      factor_type f;
      int         idx;
      idx = store_index(si_channel, s.band);
      // granule-0 long factors are kept for reuse in granule 1
      if (!si_granule && !s.is_short && s.band < LONG_BANDS) begin
         g0_store[idx]     = v;
         store_filled[idx] = 1'b1;
      end
      f.value    = v;
      f.band     = s.band;
      f.window   = s.window;
      f.is_short = s.is_short;
      f.last     = s.last;
      f.part2    = bits_used;
      expected_factors.insert(expected_factors.size(), f);
   endtask

   task automatic advance_slot(input slot_type s);
      if (s.last) begin
         gran_mode = MODE_IDLE;
      end else if (s.is_short) begin
         if (win_pos == LAST_WINDOW) begin
            win_pos  = '0;
            band_pos = band_pos + 5'd1;
         end else begin
            win_pos = win_pos + 2'd1;
         end
      end else begin
         band_pos = band_pos + 5'd1;
         win_pos  = '0;
      end
   endtask

   // Emit every factor that needs no bits, stop at the first one that does
   task automatic emit_ready_factors();
      slot_type   s;
      logic [3:0] v;
      while (gran_mode != MODE_IDLE) begin
         s = current_slot();
         if (s.pad) begin
            v = '0;
         end else if (s.copy) begin
            v = g0_store[store_index(si_channel, s.band)];
         end else if (s.width == '0) begin
            v = '0;
         end else begin
            bits_owed = s.width;
            acc       = '0;
            return;
         end
         record_factor(s, v);
         advance_slot(s);
      end
   endtask

   task automatic unpack_request();
      slot_type s;
      if (req_command == CMD_START) begin
         si_granule  = req_granule;
         si_channel  = req_channel;
         si_compress = req_compress_index;
         si_reuse    = req_reuse_groups;
         if (req_block_type == BLOCK_TYPE_SHORT && req_window_switch)
            gran_mode = req_mixed_flag ? MODE_MIXED : MODE_SHORT;
         else
            gran_mode = MODE_LONG;
         band_pos  = '0;
         win_pos   = '0;
         acc       = '0;
         bits_owed = '0;
         bits_used = '0;
         emit_ready_factors();
      end else if (gran_mode != MODE_IDLE && bits_owed != '0) begin
         acc       = {acc[2:0], req_data_bit};
         bits_used = bits_used + 7'd1;
         bits_owed = bits_owed - 3'd1;
         if (bits_owed == '0) begin
            s = current_slot();
            record_factor(s, acc);
            advance_slot(s);
            acc = '0;
            emit_ready_factors();
         end
      end
   endtask

   task automatic compare_field(input string name, input logic [6:0] want,
                                input logic [6:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         mismatches++;
      end
   endtask

   task automatic check_factor();
      factor_type want;
      if (expected_factors.size() == 0) begin
         $error("unexpected factor: value %0d band %0d window %0d",
                rsp_factor_value, rsp_band, rsp_window);
         mismatches++;
      end else begin
         want = expected_factors.pop_front();
         compare_field("factor_value", 7'(want.value), 7'(rsp_factor_value));
         compare_field("band", 7'(want.band), 7'(rsp_band));
         compare_field("window", 7'(want.window), 7'(rsp_window));
         compare_field("is_short", 7'(want.is_short), 7'(rsp_is_short));
         compare_field("last", 7'(want.last), 7'(rsp_last));
         compare_field("part2_bits", want.part2, rsp_part2_bits);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         gran_mode    = MODE_IDLE;
         band_pos     = '0;
         win_pos      = '0;
         acc          = '0;
         bits_owed    = '0;
         bits_used    = '0;
         si_granule   = 1'b0;
         si_channel   = 1'b0;
         si_compress  = '0;
         si_reuse     = '0;
         store_filled = '0;
         mismatches   = 0;
         expected_factors.delete();
      end else begin
         if (req_valid && !req_stall)
            unpack_request();
         if (rsp_valid && !rsp_stall)
            check_factor();
      end
      pending_factors = expected_factors.size();
   end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
   import l3sf_pkg::*;

   localparam int CLOCK_HALF   = 10;
   localparam int CYCLE_LIMIT  = 500000;  // worst case is far below this
   localparam int RANDOM_ITEMS = 480;
   localparam int DRAIN_CYCLES = 40;      // quiet time once nothing is outstanding

   // Non-short block types from the side info
   localparam logic [1:0] BLOCK_TYPE_NORMAL = 2'd0;
   localparam logic [1:0] BLOCK_TYPE_START  = 2'd1;
   localparam logic [1:0] BLOCK_TYPE_STOP   = 2'd3;

   typedef enum {FLOW_FREE, FLOW_SPARSE, FLOW_BLOCKS, FLOW_TOGGLE} flow_style_type;

   logic clock = 1'b0;
   logic reset;

   logic       req_valid;
   logic       req_stall;
   logic       req_command;
   logic       req_data_bit;
   logic       req_granule;
   logic       req_channel;
   logic [1:0] req_block_type;
   logic       req_window_switch;
   logic       req_mixed_flag;
   logic [3:0] req_compress_index;
   logic [3:0] req_reuse_groups;

   logic       rsp_valid;
   logic       rsp_stall;
   logic [3:0] rsp_factor_value;
   logic [4:0] rsp_band;
   logic [1:0] rsp_window;
   logic       rsp_is_short;
   logic       rsp_last;
   logic [6:0] rsp_part2_bits;

   int                     mismatches;
   int                     pending_factors;
   logic [STORE_DEPTH-1:0] store_filled;

   int cycle_count = 0;
   int counted_items;   // accepted transactions that the block acts on
   int burst_left;      // sender transactions left in the current burst

   always #(CLOCK_HALF) clock = ~clock;

   layer3_scalefactor_unpacker u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_command        (req_command),
      .req_data_bit       (req_data_bit),
      .req_granule        (req_granule),
      .req_channel        (req_channel),
      .req_block_type     (req_block_type),
      .req_window_switch  (req_window_switch),
      .req_mixed_flag     (req_mixed_flag),
      .req_compress_index (req_compress_index),
      .req_reuse_groups   (req_reuse_groups),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_factor_value   (rsp_factor_value),
      .rsp_band           (rsp_band),
      .rsp_window         (rsp_window),
      .rsp_is_short       (rsp_is_short),
      .rsp_last           (rsp_last),
      .rsp_part2_bits     (rsp_part2_bits)
   );

   // Checker watches both channels, predicts and compares
   l3sf_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_command        (req_command),
      .req_data_bit       (req_data_bit),
      .req_granule        (req_granule),
      .req_channel        (req_channel),
      .req_block_type     (req_block_type),
      .req_window_switch  (req_window_switch),
      .req_mixed_flag     (req_mixed_flag),
      .req_compress_index (req_compress_index),
      .req_reuse_groups   (req_reuse_groups),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_factor_value   (rsp_factor_value),
      .rsp_band           (rsp_band),
      .rsp_window         (rsp_window),
      .rsp_is_short       (rsp_is_short),
      .rsp_last           (rsp_last),
      .rsp_part2_bits     (rsp_part2_bits),
      .mismatches         (mismatches),
      .pending_factors    (pending_factors),
      .store_filled       (store_filled)
   );

   // Hard stop: anything still hanging by now counts as a failure
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("layer3_scalefactor_unpacker regression: fail");
         $finish;
      end
   end

   // scfsi group of a long band: 0-5, 6-10, 11-15, 16-20
   function automatic int scfsi_group(input int band);
      if (band >= GROUP3_START) return 3;
      if (band >= GROUP2_START) return 2;
      if (band >= GROUP1_START) return 1;
      return 0;
   endfunction

   // Main-data bits a granule needs once started, copied bands excluded
   function automatic int granule_bits(input logic gr, input logic [1:0] bt, input logic ws,
                                       input logic mx, input logic [3:0] ci,
                                       input logic [3:0] rg);
      int s1;
      int s2;
      int n;
      s1 = SLEN_FIRST[ci];
      s2 = SLEN_SECOND[ci];
      n  = 0;
      // short: 6 bands x 3 windows per width; mixed trades the first three
      // short bands for 8 long bands, i.e. 17 slen1 fields
      if (bt == BLOCK_TYPE_SHORT && ws)
         return (mx ? 17 : 18) * s1 + 18 * s2;
      for (int b = 0; b < LONG_BANDS; b++) begin
         if (!(gr && rg[scfsi_group(b)]))
            n += (b < LONG_SLEN2_START) ? s1 : s2;
      end
      return n;
   endfunction

   // Groups whose granule-0 values are all known for this channel; only
   // those may be reused, the store holds garbage elsewhere
   function automatic logic [3:0] copy_safe_groups(input logic ch);
      logic [3:0] ok;
      ok = 4'hF;
      for (int b = 0; b < LONG_BANDS; b++) begin
         if (!store_filled[int'(ch) * int'(LONG_BANDS) + b])
            ok[scfsi_group(b)] = 1'b0;
      end
      return ok;
   endfunction

   // One transaction on the request channel. Entered and left at a falling
   // edge; valid only drops when a gap between bursts starts.
   task automatic drive_item(input logic cmd, input logic bit_v, input logic gr,
                             input logic ch, input logic [1:0] bt, input logic ws,
                             input logic mx, input logic [3:0] ci, input logic [3:0] rg);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_command        <= cmd;
      req_data_bit       <= bit_v;
      req_granule        <= gr;
      req_channel        <= ch;
      req_block_type     <= bt;
      req_window_switch  <= ws;
      req_mixed_flag     <= mx;
      req_compress_index <= ci;
      req_reuse_groups   <= rg;
      req_valid          <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_start(input logic gr, input logic ch, input logic [1:0] bt,
                             input logic ws, input logic mx, input logic [3:0] ci,
                             input logic [3:0] rg);
      drive_item(CMD_START, 1'($urandom_range(0, 1)), gr, ch, bt, ws, mx, ci, rg);
      counted_items++;
   endtask

   // Data bits; side-info fields carry junk since the block ignores them.
   // Bits sent while no granule is open are not counted.
   task automatic send_bits(input int n, input bit ones, input bit counted);
      repeat (n) begin
         drive_item(CMD_BIT, ones ? 1'b1 : 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                    2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
                    4'($urandom_range(0, 15)));
         if (counted)
            counted_items++;
      end
   endtask

   // Hold the sender off until every predicted factor has come out
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_factors != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      burst_left = 0;
   endtask

   // Start plus bit stream with random side info. Mostly complete granules;
   // the rest are cut short and abandoned by the next start.
   task automatic random_granule();
      logic       gr;
      logic       ch;
      logic [1:0] bt;
      logic       ws;
      logic       mx;
      logic [3:0] ci;
      logic [3:0] rg;
      int         need;
      gr = 1'($urandom_range(0, 1));
      ch = 1'($urandom_range(0, 1));
      mx = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 3))
         0: begin
            bt = BLOCK_TYPE_SHORT;
            ws = 1'b1;
            mx = 1'b0;
         end
         1: begin
            bt = BLOCK_TYPE_SHORT;
            ws = 1'b1;
            mx = 1'b1;
         end
         default: begin
            do begin
               bt = 2'($urandom_range(0, 3));
               ws = 1'($urandom_range(0, 1));
            end while (bt == BLOCK_TYPE_SHORT && ws);
         end
      endcase
      // lean on the narrow slen pairs so granules stay short
      ci = $urandom_range(0, 1) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, 7));
      rg = 4'($urandom_range(0, 15));
      if (gr)
         rg &= copy_safe_groups(ch);
      need = granule_bits(gr, bt, ws, mx, ci, rg);
      send_start(gr, ch, bt, ws, mx, ci, rg);
      if ($urandom_range(0, 4) != 0) begin
         send_bits(need, 1'b0, 1'b1);
         // stray bits after the last factor: dropped by the block
         if ($urandom_range(0, 7) == 0)
            send_bits($urandom_range(1, 3), 1'b0, 1'b0);
      end else begin
         send_bits($urandom_range(0, need), 1'b0, 1'b1);
      end
   endtask

   // Receiver: switches at random between four stall styles
   initial begin
      flow_style_type flow;
      int             phase_left;
      int             hold_left;
      logic           hold_level;
      flow       = FLOW_FREE;
      phase_left = 0;
      hold_left  = 0;
      hold_level = 1'b0;
      rsp_stall  = 1'b0;
      forever begin
         @(negedge clock);
         if (phase_left == 0) begin
            flow       = flow_style_type'($urandom_range(0, 3));
            phase_left = $urandom_range(16, 160);
         end
         phase_left--;
         case (flow)
            FLOW_FREE: rsp_stall <= 1'b0;
            FLOW_SPARSE: rsp_stall <= ($urandom_range(0, 3) == 0);
            FLOW_BLOCKS: begin
               if (hold_left == 0) begin
                  hold_level = ~hold_level;
                  hold_left  = $urandom_range(1, 8);
               end
               hold_left--;
               rsp_stall <= hold_level;
            end
            default: rsp_stall <= ~rsp_stall;
         endcase
      end
   end

   // Stimulus and verdict
   initial begin
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_command        = CMD_BIT;
      req_data_bit       = 1'b0;
      req_granule        = 1'b0;
      req_channel        = 1'b0;
      req_block_type     = BLOCK_TYPE_NORMAL;
      req_window_switch  = 1'b0;
      req_mixed_flag     = 1'b0;
      req_compress_index = '0;
      req_reuse_groups   = '0;
      counted_items      = 0;
      burst_left         = 0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // --- directed ---
      // bit with no granule open: dropped
      send_bits(1, 1'b0, 1'b0);
      // zero widths: whole granule comes out on the start transaction
      // (long 22, short 39, mixed 38 factors); also fills both store halves
      send_start(1'b0, 1'b0, BLOCK_TYPE_NORMAL, 1'b0, 1'b0, 4'd0, 4'd0);
      send_start(1'b0, 1'b0, BLOCK_TYPE_SHORT, 1'b1, 1'b0, 4'd0, 4'd0);
      send_start(1'b0, 1'b0, BLOCK_TYPE_SHORT, 1'b1, 1'b1, 4'd0, 4'hF);
      send_start(1'b0, 1'b1, BLOCK_TYPE_START, 1'b0, 1'b0, 4'd0, 4'd0);
      // granule 1 with every group reused: no bits despite widest slens
      send_start(1'b1, 1'b1, BLOCK_TYPE_STOP, 1'b1, 1'b1, 4'd15, 4'hF);
      // partial reuse: groups 0 and 2 copied, bands 6-10 zero width,
      // bands 16-20 one bit each
      send_start(1'b1, 1'b0, BLOCK_TYPE_NORMAL, 1'b0, 1'b0, 4'd1, 4'b0101);
      send_bits(granule_bits(1'b1, BLOCK_TYPE_NORMAL, 1'b0, 1'b0, 4'd1, 4'b0101),
                1'b0, 1'b1);
      // 4-bit fields of all ones, then a new start abandons the granule
      send_start(1'b0, 1'b1, BLOCK_TYPE_SHORT, 1'b1, 1'b0, 4'd14, 4'd0);
      send_bits(8, 1'b1, 1'b1);
      // short block type without window switching is a long layout
      send_start(1'b0, 1'b0, BLOCK_TYPE_SHORT, 1'b0, 1'b1, 4'd0, 4'd0);
      send_bits(1, 1'b0, 1'b0);
      // sender waits for the response side to run dry
      settle();

      // --- random ---
      counted_items = 0;
      while (counted_items < RANDOM_ITEMS) begin
         random_granule();
         if ($urandom_range(0, 29) == 0)
            settle();
      end

      settle();
      if (mismatches == 0)
         $display("layer3_scalefactor_unpacker regression: pass");
      else
         $display("layer3_scalefactor_unpacker regression: fail");
      $finish;
   end

endmodule
